// ===== rtl/core/smv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_pkg
// Shared constants and codes for the semivariogram model evaluator.
// ----------------------------------------------------------------------------
package smv_pkg;

    // Fixed-point one and rounding half for 32 fraction bits
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [63:0] HALF_Q32  = 64'h0000_0000_8000_0000;
    localparam logic [31:0] INV_E_Q32 = 32'd1580030169;
    localparam logic [33:0] EXP_CUTOFF   = 34'd23;
    localparam logic [3:0]  SERIES_ORDER = 4'd13;

    // Configuration register indexes
    localparam logic [1:0] REG_MODEL_KIND = 2'd0;
    localparam logic [1:0] REG_NUGGET     = 2'd1;
    localparam logic [1:0] REG_SILL       = 2'd2;
    localparam logic [1:0] REG_RANGE      = 2'd3;

    // Model codes
    localparam logic [1:0] MODEL_SPHERICAL   = 2'd0;
    localparam logic [1:0] MODEL_EXPONENTIAL = 2'd1;

    // Row kinds
    localparam logic [1:0] ROW_HEADER = 2'd0;
    localparam logic [1:0] ROW_LAG    = 2'd1;
    localparam logic [1:0] ROW_TAIL   = 2'd2;

endpackage

// ===== rtl/core/semivariogram_model_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semivariogram_model_eval
// Spherical / exponential / Gaussian semivariogram rows from a lag stream.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    tdata: lag_distance; tlast: is_last
//  m_        out  m_tvalid/m_tready    tdata: out_distance, gamma_value;
//                                      tuser: row_kind; tlast: end_of_run
//  cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item at a time; s_tready is high only while the sequencer is idle.
//  Per lag: a bit-serial divide (h/a, or 3h/a for the exponential model),
//  then multiplies on the shared 32x32 multiplier. The exponential and
//  Gaussian models add 13 series steps (each one multiply plus a divide
//  by the series index) and one multiply per e^-1 scaling step; a lag past
//  the cutoff skips them.
//  Each emitted row waits for m_tready.
//  Reset (aresetn, synchronous) loads the register defaults and closes any
//  open stream.
// ----------------------------------------------------------------------------
module semivariogram_model_eval
    import smv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] lag_distance
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [32:0] out_distance, [65:33] gamma_value, zeros
    output logic [1:0]  m_tuser,   // [1:0] row_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_HDR, S_EVAL, S_DIV, S_DIVW, S_MUL, S_MULW,
        S_EXPS, S_SERIES, S_SCALE, S_FINAL, S_LAG, S_TAIL
    } state_t;

    typedef enum logic [2:0] {
        ST_SPH_R2, ST_SPH_R3, ST_GAU_SQ, ST_EXP_T, ST_EXP_Q, ST_FINAL
    } step_t;

    typedef enum logic {DV_MAIN, DV_SERIES} div_ret_t;

    state_t      state_reg;
    step_t       step_reg;
    div_ret_t    div_ret_reg;

    logic [1:0]  kind_reg;
    logic [31:0] nugget_reg, sill_reg, range_reg;

    logic        in_stream_reg;
    logic [31:0] prev_dist_reg, last_dist_reg;
    logic [32:0] last_gamma_reg;

    logic [31:0] h_reg;
    logic        last_in_reg;

    logic [32:0] rem_reg;
    logic [65:0] nq_reg;
    logic [31:0] div_d_reg;
    logic [6:0]  div_cnt_reg;

    logic [31:0] mul_a_reg;
    logic [32:0] mul_b_reg;
    logic [63:0] prod_reg;
    logic        mul_byp_reg;

    logic [31:0] frac_reg;
    logic [1:0]  rq_reg;
    logic [4:0]  qcnt_reg;
    logic        exp_zero_reg;
    logic [32:0] p_reg, shape_reg, gamma_reg;
    logic [3:0]  n_reg;

    logic        m_tvalid_reg, m_tlast_reg;
    logic [32:0] m_dist_reg, m_gamma_reg;
    logic [1:0]  m_kind_reg;

    // Datapath helpers
    logic        out_free;
    logic        row_load;
    logic [32:0] rem_sh, rem_sub;
    logic        div_ge;
    logic [31:0] mul_res;
    logic [33:0] three_r;
    logic [32:0] sph_shape;
    logic [35:0] gau_sq;
    logic [36:0] gau_x;
    logic [33:0] ser_num;
    logic [33:0] div_num;
    logic [32:0] twice_last, tail_dist;

    assign out_free = !m_tvalid_reg || m_tready;
    assign row_load = out_free &&
                      (state_reg == S_HDR || state_reg == S_LAG || state_reg == S_TAIL);

    assign rem_sh  = {rem_reg[31:0], nq_reg[65]};
    assign div_ge  = rem_sh >= {1'b0, div_d_reg};
    assign rem_sub = rem_sh - {1'b0, div_d_reg};

    assign mul_res = mul_byp_reg ? mul_a_reg : prod_reg[63:32] + 32'(prod_reg[31]);

    assign three_r   = {2'b00, frac_reg} + {1'b0, frac_reg, 1'b0};
    assign sph_shape = 33'((three_r - {2'b00, mul_res}) >> 1);

    always_comb begin
        case (rq_reg)
            2'd1:    gau_sq = {4'd1, 32'd0} + {3'd0, frac_reg, 1'b0};
            2'd2:    gau_sq = {4'd4, 32'd0} + {2'd0, frac_reg, 2'b00};
            default: gau_sq = 36'd0;
        endcase
    end
    assign gau_x = {gau_sq + {4'd0, prod_reg[63:32]}, 1'b0}
                 + {1'b0, gau_sq + {4'd0, prod_reg[63:32]}};

    assign ser_num = {2'b00, mul_res} + {31'd0, n_reg[3:1]};
    assign div_num = (kind_reg == MODEL_EXPONENTIAL)
                   ? {1'b0, h_reg, 1'b0} + {2'b00, h_reg} : {2'b00, h_reg};

    assign twice_last = {last_dist_reg, 1'b0};
    assign tail_dist  = (twice_last >= {1'b0, prev_dist_reg})
                      ? twice_last - {1'b0, prev_dist_reg} : 33'd0;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'd0, m_gamma_reg, m_dist_reg};
    assign m_tuser   = m_kind_reg;
    assign m_tlast   = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            kind_reg      <= MODEL_SPHERICAL;
            nugget_reg    <= 32'd0;
            sill_reg      <= 32'd65536;
            range_reg     <= 32'd65536;
            in_stream_reg <= 1'b0;
            prev_dist_reg <= 32'd0;
            last_dist_reg <= 32'd0;
            last_gamma_reg <= 33'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MODEL_KIND: kind_reg   <= cfg_data[1:0];
                    REG_NUGGET:     nugget_reg <= cfg_data;
                    REG_SILL:       sill_reg   <= cfg_data;
                    REG_RANGE:      range_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // drop the accepted row unless a new one is loaded in its place
            if (m_tready && !row_load) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        h_reg       <= s_tdata;
                        last_in_reg <= s_tlast;
                        if (!in_stream_reg) begin
                            prev_dist_reg <= 32'd0;
                            last_dist_reg <= 32'd0;
                            state_reg     <= S_HDR;
                        end else begin
                            prev_dist_reg <= last_dist_reg;
                            state_reg     <= S_EVAL;
                        end
                    end
                end
                S_HDR: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_dist_reg   <= 33'd0;
                        m_gamma_reg  <= {1'b0, nugget_reg};
                        m_kind_reg   <= ROW_HEADER;
                        m_tlast_reg  <= 1'b0;
                        state_reg    <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (h_reg == 32'd0) begin
                        gamma_reg <= {1'b0, nugget_reg};
                        state_reg <= S_LAG;
                    end else if (range_reg == 32'd0 ||
                                 (kind_reg == MODEL_SPHERICAL && h_reg >= range_reg)) begin
                        gamma_reg <= {1'b0, nugget_reg} + {1'b0, sill_reg};
                        state_reg <= S_LAG;
                    end else begin
                        rem_reg     <= 33'd0;
                        nq_reg      <= {div_num, 32'd0};
                        div_d_reg   <= range_reg;
                        div_cnt_reg <= 7'd66;
                        div_ret_reg <= DV_MAIN;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    rem_reg     <= div_ge ? rem_sub : rem_sh;
                    nq_reg      <= {nq_reg[64:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - 7'd1;
                    if (div_cnt_reg == 7'd1) begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (div_ret_reg == DV_SERIES) begin
                        p_reg     <= ONE_Q32 - nq_reg[32:0];
                        n_reg     <= n_reg - 4'd1;
                        state_reg <= S_SERIES;
                    end else if (kind_reg == MODEL_SPHERICAL) begin
                        frac_reg  <= nq_reg[31:0];
                        mul_a_reg <= nq_reg[31:0];
                        mul_b_reg <= {1'b0, nq_reg[31:0]};
                        step_reg  <= ST_SPH_R2;
                        state_reg <= S_MUL;
                    end else if (kind_reg == MODEL_EXPONENTIAL) begin
                        frac_reg     <= nq_reg[31:0];
                        exp_zero_reg <= nq_reg[65:32] >= EXP_CUTOFF;
                        qcnt_reg     <= nq_reg[36:32];
                        state_reg    <= S_EXPS;
                    end else if (nq_reg[65:32] >= 34'd3) begin
                        shape_reg <= ONE_Q32;
                        state_reg <= S_FINAL;
                    end else begin
                        rq_reg    <= nq_reg[33:32];
                        frac_reg  <= nq_reg[31:0];
                        mul_a_reg <= nq_reg[31:0];
                        mul_b_reg <= {1'b0, nq_reg[31:0]};
                        step_reg  <= ST_GAU_SQ;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg    <= mul_a_reg * mul_b_reg[31:0];
                    mul_byp_reg <= mul_b_reg[32];
                    state_reg   <= S_MULW;
                end
                S_MULW: begin
                    unique case (step_reg)
                        ST_SPH_R2: begin
                            mul_a_reg <= mul_res;
                            mul_b_reg <= {1'b0, frac_reg};
                            step_reg  <= ST_SPH_R3;
                            state_reg <= S_MUL;
                        end
                        ST_SPH_R3: begin
                            shape_reg <= sph_shape;
                            state_reg <= S_FINAL;
                        end
                        ST_GAU_SQ: begin
                            frac_reg     <= gau_x[31:0];
                            exp_zero_reg <= gau_x[36:32] >= EXP_CUTOFF[4:0];
                            qcnt_reg     <= gau_x[36:32];
                            state_reg    <= S_EXPS;
                        end
                        ST_EXP_T: begin
                            // rounded divide by the series index
                            rem_reg     <= 33'd0;
                            nq_reg      <= {ser_num, 32'd0};
                            div_d_reg   <= {28'd0, n_reg};
                            div_cnt_reg <= 7'd34;
                            div_ret_reg <= DV_SERIES;
                            state_reg   <= S_DIV;
                        end
                        ST_EXP_Q: begin
                            p_reg     <= {1'b0, mul_res};
                            qcnt_reg  <= qcnt_reg - 5'd1;
                            state_reg <= S_SCALE;
                        end
                        ST_FINAL: begin
                            gamma_reg <= {1'b0, nugget_reg} + {1'b0, mul_res};
                            state_reg <= S_LAG;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_EXPS: begin
                    if (exp_zero_reg) begin
                        shape_reg <= ONE_Q32;
                        state_reg <= S_FINAL;
                    end else begin
                        p_reg     <= ONE_Q32;
                        n_reg     <= SERIES_ORDER;
                        state_reg <= S_SERIES;
                    end
                end
                S_SERIES: begin
                    if (n_reg == 4'd0) begin
                        state_reg <= S_SCALE;
                    end else begin
                        mul_a_reg <= frac_reg;
                        mul_b_reg <= p_reg;
                        step_reg  <= ST_EXP_T;
                        state_reg <= S_MUL;
                    end
                end
                S_SCALE: begin
                    if (qcnt_reg == 5'd0) begin
                        shape_reg <= ONE_Q32 - p_reg;
                        state_reg <= S_FINAL;
                    end else begin
                        mul_a_reg <= INV_E_Q32;
                        mul_b_reg <= p_reg;
                        step_reg  <= ST_EXP_Q;
                        state_reg <= S_MUL;
                    end
                end
                S_FINAL: begin
                    mul_a_reg <= sill_reg;
                    mul_b_reg <= shape_reg;
                    step_reg  <= ST_FINAL;
                    state_reg <= S_MUL;
                end
                S_LAG: begin
                    if (out_free) begin
                        m_tvalid_reg   <= 1'b1;
                        m_dist_reg     <= {1'b0, h_reg};
                        m_gamma_reg    <= gamma_reg;
                        m_kind_reg     <= ROW_LAG;
                        m_tlast_reg    <= !last_in_reg;
                        last_dist_reg  <= h_reg;
                        last_gamma_reg <= gamma_reg;
                        in_stream_reg  <= !last_in_reg;
                        state_reg      <= last_in_reg ? S_TAIL : S_IDLE;
                    end
                end
                S_TAIL: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_dist_reg   <= tail_dist;
                        m_gamma_reg  <= last_gamma_reg;
                        m_kind_reg   <= ROW_TAIL;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/smv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_checker
// Port-level checks for the semivariogram model evaluator.
// ----------------------------------------------------------------------------
module smv_checker
    import smv_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result item stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // an accepted item blocks the input for at least the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // a tail row always closes the run, a header row never does
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ROW_TAIL |-> m_tlast)
        else $error("tail row without end of run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ROW_HEADER |-> !m_tlast)
        else $error("header row marked end of run");

endmodule

bind semivariogram_model_eval smv_checker u_smv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
